// ===== sv/mwep_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mwep_pkg
// Shared constants and types for the serial EEPROM port: register reset
// values, EEPROM image layout and the command decode fields.
// ----------------------------------------------------------------------------
package mwep_pkg;

	localparam int unsigned EEPROM_WORDS = 64;
	localparam int unsigned EE_AW        = $clog2(EEPROM_WORDS);
	localparam int unsigned DIRECT_AW    = 7;

	localparam logic [31:0] ADDR_LOW_RST  = 32'h1200_5452;
	localparam logic [15:0] ADDR_HIGH_RST = 16'h5634;

	localparam logic [15:0] IMG_CHECKSUM  = 16'hBABA;
	localparam logic [15:0] IMG_WORD10    = 16'h8000;
	localparam logic [EE_AW-1:0] IMG_IDX_LO    = EE_AW'(0);
	localparam logic [EE_AW-1:0] IMG_IDX_MID   = EE_AW'(1);
	localparam logic [EE_AW-1:0] IMG_IDX_HI    = EE_AW'(2);
	localparam logic [EE_AW-1:0] IMG_IDX_W10   = EE_AW'(10);
	localparam logic [EE_AW-1:0] IMG_IDX_SUM   = EE_AW'(EEPROM_WORDS - 1);

	localparam logic [2:0]  OP_READ       = 3'h6;
	localparam logic [3:0]  CMD_BITS      = 4'd9;
	localparam logic [3:0]  CNT_MAX       = 4'd15;
	localparam logic [3:0]  BIT_MSB       = 4'd15;
	localparam logic [31:0] DIRECT_DONE   = 32'h0000_0010;

	// control register bit positions
	localparam int unsigned CTL_CLK   = 0;
	localparam int unsigned CTL_CS    = 1;
	localparam int unsigned CTL_DI    = 2;
	localparam int unsigned CTL_DO    = 3;
	localparam int unsigned CTL_REQ   = 6;
	localparam int unsigned CTL_GNT   = 7;

	localparam logic        FUNC_CTL    = 1'b0;
	localparam logic        FUNC_DIRECT = 1'b1;

	localparam logic        REG_ADDR_LOW  = 1'b0;
	localparam logic        REG_ADDR_HIGH = 1'b1;

	typedef struct packed {
		logic [31:0] addr_low;
		logic [15:0] addr_high;
	} station_t;

endpackage
`default_nettype wire

// ===== sv/mwep_cfg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mwep_cfg
// APB register file holding the station address used to build the EEPROM
// image.
// ----------------------------------------------------------------------------
module mwep_cfg (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire logic [2:0]          paddr,
	input  wire logic [31:0]         pwdata,
	output logic [31:0]              prdata,
	output logic                     pready,
	output mwep_pkg::station_t       station
);

	logic [31:0] addr_low_q;
	logic [15:0] addr_high_q;
	logic        wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_low_q  <= mwep_pkg::ADDR_LOW_RST;
			addr_high_q <= mwep_pkg::ADDR_HIGH_RST;
		end else if (wr_en) begin
			unique case (paddr[2])
				mwep_pkg::REG_ADDR_LOW:  addr_low_q  <= pwdata;
				mwep_pkg::REG_ADDR_HIGH: addr_high_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			mwep_pkg::REG_ADDR_LOW:  prdata = addr_low_q;
			mwep_pkg::REG_ADDR_HIGH: prdata = {16'h0000, addr_high_q};
			default:                 prdata = 32'h0000_0000;
		endcase
	end

	assign station.addr_low  = addr_low_q;
	assign station.addr_high = addr_high_q;

endmodule
`default_nettype wire

// ===== sv/mwep_image.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mwep_image
// EEPROM image lookup: address words, fixed word ten and checksum word.
// ----------------------------------------------------------------------------
module mwep_image (
	input  wire mwep_pkg::station_t          station,
	input  wire logic [mwep_pkg::EE_AW-1:0]  idx,
	output logic [15:0]                      word
);

	logic [15:0] checksum;

	assign checksum = mwep_pkg::IMG_CHECKSUM - station.addr_low[15:0]
		- station.addr_low[31:16] - station.addr_high - mwep_pkg::IMG_WORD10;

	always_comb begin
		unique case (idx)
			mwep_pkg::IMG_IDX_LO:  word = station.addr_low[15:0];
			mwep_pkg::IMG_IDX_MID: word = station.addr_low[31:16];
			mwep_pkg::IMG_IDX_HI:  word = station.addr_high;
			mwep_pkg::IMG_IDX_W10: word = mwep_pkg::IMG_WORD10;
			mwep_pkg::IMG_IDX_SUM: word = checksum;
			default:               word = 16'h0000;
		endcase
	end

endmodule
`default_nettype wire

// ===== sv/mwep_engine.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mwep_engine
// Input register, serial command engine and result register for the
// control and direct read register writes.
// ----------------------------------------------------------------------------
module mwep_engine (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire mwep_pkg::station_t station,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire logic          func,
	input  wire logic [31:0]   write_value,
	output logic               out_valid,
	input  wire logic          out_stall,
	output logic [31:0]        register_value,
	output logic               data_out_bit,
	output logic               in_data_phase
);

	localparam int unsigned AW = mwep_pkg::EE_AW;

	logic        valid_s1;
	logic        func_s1;
	logic [31:0] value_s1;

	logic        out_valid_q;
	logic [31:0] reg_val_q;
	logic        dout_q;
	logic        phase_q;

	logic        prev_clk_q;
	logic        shifting_q;
	logic [3:0]  bits_seen_q;
	logic [8:0]  cmd_q;
	logic [15:0] word_q;
	logic [3:0]  bit_idx_q;

	logic        out_hold;
	logic        advance;
	logic        load_s1;

	logic        prev_clk_d;
	logic        shifting_d;
	logic [3:0]  bits_seen_d;
	logic [8:0]  cmd_d;
	logic [15:0] word_d;
	logic [3:0]  bit_idx_d;
	logic [31:0] res_val;
	logic        res_dout;

	logic [AW-1:0] img_idx;
	logic [15:0]   img_word;
	logic [mwep_pkg::DIRECT_AW-1:0] direct_addr;
	logic          direct_ok;
	logic [31:0]   ctl_val;

	function automatic logic [31:0] write_value_grant(input logic [31:0] v);
		logic [31:0] r;
		r = v;
		if (v[mwep_pkg::CTL_REQ]) begin
			r[mwep_pkg::CTL_GNT] = 1'b1;
		end
		return r;
	endfunction

	assign out_hold = out_valid_q & out_stall;
	assign advance  = valid_s1 & ~out_hold;
	assign in_stall = valid_s1 & out_hold;
	assign load_s1  = in_valid & ~in_stall;

	assign direct_addr = value_s1[8 +: mwep_pkg::DIRECT_AW];
	assign direct_ok   = direct_addr < mwep_pkg::DIRECT_AW'(mwep_pkg::EEPROM_WORDS);
	assign img_idx     = (func_s1 == mwep_pkg::FUNC_DIRECT) ? direct_addr[AW-1:0]
		: {cmd_q[AW-2:0], value_s1[mwep_pkg::CTL_DI]};

	mwep_image u_image (
		.station (station),
		.idx     (img_idx),
		.word    (img_word)
	);

	always_comb begin
		prev_clk_d  = prev_clk_q;
		shifting_d  = shifting_q;
		bits_seen_d = bits_seen_q;
		cmd_d       = cmd_q;
		word_d      = word_q;
		bit_idx_d   = bit_idx_q;
		ctl_val     = write_value_grant(value_s1);
		res_val     = value_s1;
		res_dout    = 1'b0;

		if (func_s1 == mwep_pkg::FUNC_DIRECT) begin
			if (value_s1[0]) begin
				res_val = mwep_pkg::DIRECT_DONE
					| {(direct_ok ? img_word : 16'h0000), 16'h0000};
			end
		end else begin
			if (!value_s1[mwep_pkg::CTL_CS]) begin
				shifting_d  = 1'b0;
				bits_seen_d = 4'd0;
				cmd_d       = 9'd0;
				word_d      = 16'h0000;
				bit_idx_d   = 4'd0;
			end else if (value_s1[mwep_pkg::CTL_CLK] && !prev_clk_q) begin
				if (!shifting_q) begin
					cmd_d = {cmd_q[7:0], value_s1[mwep_pkg::CTL_DI]};
					if (bits_seen_q != mwep_pkg::CNT_MAX) begin
						bits_seen_d = bits_seen_q + 4'd1;
					end
					if (bits_seen_d == mwep_pkg::CMD_BITS
						&& cmd_d[8:6] == mwep_pkg::OP_READ) begin
						word_d     = img_word;
						bit_idx_d  = mwep_pkg::BIT_MSB;
						shifting_d = 1'b1;
					end
				end else begin
					ctl_val[mwep_pkg::CTL_DO] = word_q[bit_idx_q];
					if (bit_idx_q != 4'd0) begin
						bit_idx_d = bit_idx_q - 4'd1;
					end
				end
			end
			prev_clk_d = value_s1[mwep_pkg::CTL_CLK];
			res_val    = ctl_val;
			res_dout   = ctl_val[mwep_pkg::CTL_DO];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			prev_clk_q  <= 1'b0;
			shifting_q  <= 1'b0;
			bits_seen_q <= 4'd0;
			cmd_q       <= 9'd0;
			word_q      <= 16'h0000;
			bit_idx_q   <= 4'd0;
		end else begin
			if (load_s1) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (advance && func_s1 == mwep_pkg::FUNC_CTL) begin
				prev_clk_q  <= prev_clk_d;
				shifting_q  <= shifting_d;
				bits_seen_q <= bits_seen_d;
				cmd_q       <= cmd_d;
				word_q      <= word_d;
				bit_idx_q   <= bit_idx_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			func_s1  <= func;
			value_s1 <= write_value;
		end
		if (advance) begin
			reg_val_q <= res_val;
			dout_q    <= res_dout;
			phase_q   <= (func_s1 == mwep_pkg::FUNC_CTL) ? shifting_d : shifting_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign register_value = reg_val_q;
	assign data_out_bit   = dout_q;
	assign in_data_phase  = phase_q;

endmodule
`default_nettype wire

// ===== sv/eeprom_microwire_and_read_port.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// eeprom_microwire_and_read_port
// Serial EEPROM port with bit-banged control register and direct read
// register over an image built from the station address.
// ----------------------------------------------------------------------------
// Each transaction on the input channel is one 32-bit write to the control
// register (func 0) or the direct read register (func 1); the output channel
// returns the value that register reads back, the serial data-out level and
// whether the engine is shifting out a word. One transaction is taken every
// clock cycle unless the output stalls; results pass the input register and
// the result register around the combinational engine update. The station
// address lives in two APB registers (address_low at 0x0, address_high at
// 0x4); the user must write it only while the port is idle (not enforced).
module eeprom_microwire_and_read_port (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        func,
	input  wire logic [31:0] write_value,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      register_value,
	output logic             data_out_bit,
	output logic             in_data_phase
);

	mwep_pkg::station_t station;

	mwep_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.station (station)
	);

	mwep_engine u_engine (
		.clk            (clk),
		.arst_n         (arst_n),
		.station        (station),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.func           (func),
		.write_value    (write_value),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.register_value (register_value),
		.data_out_bit   (data_out_bit),
		.in_data_phase  (in_data_phase)
	);

endmodule
`default_nettype wire

// ===== sim/eeprom_microwire_and_read_port_test.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// eeprom_microwire_and_read_port_test
// Self-checking testbench for the serial EEPROM port. Register writes go in
// on the input channel, and a cycle-free model of the serial engine and the
// direct read path predicts every readback. Each readback is compared with the
// oldest prediction. Traffic is mostly well-formed serial read commands with
// random content, plus aborted commands, direct reads and noise. Both sides
// insert random idle bursts. The station address is rewritten over APB
// between phases, with the extremes among the settings.
// ----------------------------------------------------------------------------
module eeprom_microwire_and_read_port_test;

	import mwep_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES  = 6;
	localparam int MAX_REPORTS    = 10;

	typedef struct packed {
		logic [31:0] value;
		logic        dout;
		logic        phase;
	} readback_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid;
	logic        in_stall;
	logic        func;
	logic [31:0] write_value;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] register_value;
	logic        data_out_bit;
	logic        in_data_phase;

	station_t    station;
	logic        ser_prev_clk;
	logic        ser_shifting;
	logic [3:0]  ser_bits_seen;
	logic [8:0]  ser_cmd;
	logic [15:0] ser_word;
	logic [3:0]  ser_bit_idx;

	readback_t   readback_q[$];
	readback_t   exp_rb;
	int          failures     = 0;
	int          writes_sent  = 0;
	int          quiet_cycles = 0;
	int          gap_odds     = 0;
	int          stall_odds   = 0;
	int          stall_left   = 0;
	bit          calm         = 1'b0;

	eeprom_microwire_and_read_port dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.func           (func),
		.write_value    (write_value),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.register_value (register_value),
		.data_out_bit   (data_out_bit),
		.in_data_phase  (in_data_phase)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [15:0] image_raw_word(input logic [EE_AW-1:0] idx);
		case (idx)
			IMG_IDX_LO:  return station.addr_low[15:0];
			IMG_IDX_MID: return station.addr_low[31:16];
			IMG_IDX_HI:  return station.addr_high;
			IMG_IDX_W10: return IMG_WORD10;
			default:     return 16'h0000;
		endcase
	endfunction

	function automatic logic [15:0] image_word(input logic [DIRECT_AW-1:0] idx);
		logic [15:0] sum;
		sum = 16'h0000;
		if (idx >= EEPROM_WORDS)
			return 16'h0000;
		if (idx[EE_AW-1:0] != IMG_IDX_SUM)
			return image_raw_word(idx[EE_AW-1:0]);
		for (int i = 0; i < EEPROM_WORDS - 1; i++)
			sum = sum + image_raw_word(EE_AW'(i));
		return IMG_CHECKSUM - sum;
	endfunction

	function automatic void clear_engine();
		ser_prev_clk  = 1'b0;
		ser_shifting  = 1'b0;
		ser_bits_seen = 4'd0;
		ser_cmd       = 9'd0;
		ser_word      = 16'h0000;
		ser_bit_idx   = 4'd0;
	endfunction

	function automatic void predict_readback(input logic f, input logic [31:0] v);
		logic [31:0] val;
		val = v;
		if (f == FUNC_DIRECT) begin
			if (val[0])
				val = DIRECT_DONE | {image_word(val[14:8]), 16'h0000};
			readback_q.push_back('{val, 1'b0, ser_shifting});
			return;
		end
		if (val[CTL_REQ])
			val[CTL_GNT] = 1'b1;
		if (!val[CTL_CS]) begin
			clear_engine();
		end else if (val[CTL_CLK] && !ser_prev_clk) begin
			if (!ser_shifting) begin
				ser_cmd = {ser_cmd[7:0], val[CTL_DI]};
				if (ser_bits_seen < CNT_MAX)
					ser_bits_seen = ser_bits_seen + 4'd1;
				if (ser_bits_seen == CMD_BITS && ser_cmd[8:6] == OP_READ) begin
					ser_word     = image_word({1'b0, ser_cmd[5:0]});
					ser_bit_idx  = BIT_MSB;
					ser_shifting = 1'b1;
				end
			end else begin
				val[CTL_DO] = ser_word[ser_bit_idx];
				if (ser_bit_idx != 4'd0)
					ser_bit_idx = ser_bit_idx - 4'd1;
			end
		end
		ser_prev_clk = val[CTL_CLK];
		readback_q.push_back('{val, val[CTL_DO], ser_shifting});
	endfunction

	function automatic void note_failure(input string msg);
		failures++;
		if (failures <= MAX_REPORTS)
			$display("[%0t] readback mismatch %0d: %s", $realtime, failures, msg);
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (readback_q.size() == 0) begin
					note_failure($sformatf("unexpected value %h dout %b phase %b",
						register_value, data_out_bit, in_data_phase));
				end else begin
					exp_rb = readback_q.pop_front();
					if (register_value !== exp_rb.value || data_out_bit !== exp_rb.dout ||
							in_data_phase !== exp_rb.phase)
						note_failure($sformatf(
							"expected value %h dout %b phase %b, got value %h dout %b phase %b",
							exp_rb.value, exp_rb.dout, exp_rb.phase,
							register_value, data_out_bit, in_data_phase));
				end
			end
			if ((out_valid && !out_stall) || (in_valid && !in_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (stall_left != 0) begin
				out_stall  <= 1'b1;
				stall_left <= stall_left - 1;
			end else if (!calm && stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
				out_stall  <= 1'b1;
				stall_left <= $urandom_range(0, 15);
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		while (quiet_cycles < WATCHDOG_LIMIT)
			@(posedge clk);
		$display("Regression FAIL");
		$finish;
	end

	task automatic send_write(input logic f, input logic [31:0] v);
		if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		in_valid    <= 1'b1;
		func        <= f;
		write_value <= v;
		predict_readback(f, v);
		do @(posedge clk); while (in_stall);
		writes_sent++;
	endtask

	task automatic settle_port();
		in_valid <= 1'b0;
		while (readback_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(input logic idx, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_station(input logic [31:0] lo, input logic [31:0] hi_word);
		settle_port();
		apb_write(REG_ADDR_LOW, lo);
		station.addr_low = lo;
		apb_write(REG_ADDR_HIGH, hi_word);
		station.addr_high = hi_word[15:0];
	endtask

	function automatic logic [31:0] ctl_word(input logic cs, input logic sck, input logic di);
		logic [31:0] v;
		v          = $urandom;
		v[CTL_CS]  = cs;
		v[CTL_CLK] = sck;
		v[CTL_DI]  = di;
		return v;
	endfunction

	function automatic logic [EE_AW-1:0] pick_addr();
		case ($urandom_range(0, 5))
			0:       return IMG_IDX_LO;
			1:       return IMG_IDX_MID;
			2:       return IMG_IDX_HI;
			3:       return IMG_IDX_W10;
			4:       return IMG_IDX_SUM;
			default: return EE_AW'($urandom);
		endcase
	endfunction

	function automatic logic [31:0] direct_probe();
		logic [31:0] v;
		v = $urandom;
		v[0] = 1'b1;
		if ($urandom_range(0, 2) != 0)
			v[14:8] = {1'b0, pick_addr()};
		return v;
	endfunction

	function automatic void pick_idling();
		case ($urandom_range(0, 2))
			0:       gap_odds = 0;
			1:       gap_odds = 3;
			default: gap_odds = 10;
		endcase
		case ($urandom_range(0, 2))
			0:       stall_odds = 0;
			1:       stall_odds = 3;
			default: stall_odds = 10;
		endcase
	endfunction

	task automatic run_serial_read(input bit broken);
		logic [8:0] cmd;
		logic       di;
		int         edges;
		int         cut;
		cmd[8:6] = ($urandom_range(0, 4) != 0) ? OP_READ : 3'($urandom);
		cmd[5:0] = pick_addr();
		edges    = CMD_BITS + 16 + $urandom_range(0, 4);
		cut      = broken ? $urandom_range(1, edges) : edges;
		if ($urandom_range(0, 7) != 0)
			send_write(FUNC_CTL, ctl_word(1'b0, 1'($urandom), 1'($urandom)));
		for (int n = 0; n < cut; n++) begin
			di = (n < CMD_BITS) ? cmd[8 - n] : 1'($urandom);
			send_write(FUNC_CTL, ctl_word(1'b1, 1'b0, di));
			send_write(FUNC_CTL, ctl_word(1'b1, 1'b1, di));
			if ($urandom_range(0, 15) == 0)
				send_write(FUNC_CTL, ctl_word(1'b1, 1'b1, 1'($urandom)));
			if ($urandom_range(0, 31) == 0)
				send_write(FUNC_DIRECT, direct_probe());
		end
		if (!broken || $urandom_range(0, 1) == 0)
			send_write(FUNC_CTL, ctl_word(1'b0, 1'($urandom), 1'($urandom)));
	endtask

	task automatic run_noise();
		repeat ($urandom_range(1, 10)) begin
			case ($urandom_range(0, 3))
				0:       send_write(FUNC_DIRECT, direct_probe());
				1:       send_write(FUNC_DIRECT, $urandom);
				default: send_write(FUNC_CTL, $urandom);
			endcase
		end
	endtask

	task automatic run_traffic(input int goal);
		int pick;
		while (writes_sent < goal) begin
			pick_idling();
			pick = $urandom_range(0, 9);
			if (pick < 6)
				run_serial_read(1'b0);
			else if (pick < 8)
				run_serial_read(1'b1);
			else
				run_noise();
		end
	endtask

	task automatic test_direct_read();
		send_write(FUNC_DIRECT, 32'h0000_0001);
		send_write(FUNC_DIRECT, 32'h0000_0101);
		send_write(FUNC_DIRECT, 32'h0000_0201);
		send_write(FUNC_DIRECT, 32'h0000_0A01);
		send_write(FUNC_DIRECT, 32'h0000_3F01);
		send_write(FUNC_DIRECT, 32'h0000_4001);
		send_write(FUNC_DIRECT, 32'h0000_7F01);
		send_write(FUNC_DIRECT, 32'hFFFF_FFFF);
		send_write(FUNC_DIRECT, 32'hFFFF_FFFE);
		send_write(FUNC_DIRECT, 32'h0000_0000);
	endtask

	task automatic test_control_register();
		send_write(FUNC_CTL, 32'h0000_0000);
		send_write(FUNC_CTL, 32'h0000_0040);
		send_write(FUNC_CTL, 32'hFFFF_FFFF);
		send_write(FUNC_CTL, 32'hFFFF_FFFF);
		send_write(FUNC_CTL, 32'hFFFF_FFFE);
		send_write(FUNC_CTL, 32'h0000_0002);
		send_write(FUNC_CTL, 32'hFFFF_FFBD);
		send_write(FUNC_CTL, 32'h0000_0003);
		send_write(FUNC_CTL, 32'h0000_0000);
	endtask

	task automatic test_serial_reads();
		run_traffic(writes_sent + 150);
		settle_port();
		run_traffic(writes_sent + 150);
	endtask

	task automatic test_station_address();
		set_station(32'h0000_0000, 32'h0000_0000);
		run_traffic(writes_sent + 130);
		set_station(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		run_traffic(writes_sent + 130);
		set_station($urandom, $urandom);
		run_traffic(writes_sent + 130);
		set_station($urandom, $urandom);
		run_traffic(writes_sent + 130);
	endtask

	task automatic test_back_to_back();
		set_station(ADDR_LOW_RST, {16'h0000, ADDR_HIGH_RST});
		calm       = 1'b1;
		gap_odds   = 0;
		stall_odds = 0;
		while (writes_sent < 960) begin
			if ($urandom_range(0, 3) != 0)
				run_serial_read(1'b0);
			else
				run_noise();
		end
	endtask

	initial begin
		arst_n      = 1'b0;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = 3'd0;
		pwdata      = 32'h0;
		in_valid    = 1'b0;
		func        = FUNC_CTL;
		write_value = 32'h0;
		out_stall   = 1'b0;
		station     = '{ADDR_LOW_RST, ADDR_HIGH_RST};
		clear_engine();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_direct_read();
		test_control_register();
		test_serial_reads();
		test_station_address();
		test_back_to_back();
		settle_port();
		if (failures == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
`default_nettype wire

// ===== eeprom_microwire_and_read_port.f =====
sv/mwep_pkg.sv
sv/mwep_cfg.sv
sv/mwep_image.sv
sv/mwep_engine.sv
sv/eeprom_microwire_and_read_port.sv
sim/eeprom_microwire_and_read_port_test.sv
